// ----- sv/jbps_pkg.sv -----
`timescale 1ns / 1ps

package jbps_pkg;

  localparam int unsigned CmdW     = 2;
  localparam int unsigned CodeW    = 16;
  localparam int unsigned LenW     = 5;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned PendW    = 7;
  localparam int unsigned CntW     = 3;
  localparam int unsigned AccW     = PendW + CodeW;
  localparam int unsigned TotW     = 5;

  localparam logic [CmdW-1:0] CmdAppend = 2'd0;
  localparam logic [CmdW-1:0] CmdAlign  = 2'd1;
  localparam logic [CmdW-1:0] CmdRaw    = 2'd2;

  localparam logic [ByteW-1:0] ByteFf    = 8'hFF;
  localparam logic [ByteW-1:0] ByteStuff = 8'h00;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic emit_byte;
    logic emit_stuff;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic ld_emits;
    logic more;
    logic final_byte;
    logic byte_ff;
    logic out_free;
  } sts_t;

endpackage

// ----- sv/jbps_datapath.sv -----
`timescale 1ns / 1ps

module jbps_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  jbps_pkg::cmd_t                   cmd_i,
  output jbps_pkg::sts_t                   sts_o,
  input  logic [jbps_pkg::CmdW-1:0]        command_i,
  input  logic [jbps_pkg::CodeW-1:0]       code_value_i,
  input  logic [jbps_pkg::LenW-1:0]        code_length_i,
  input  logic [jbps_pkg::ByteW-1:0]       raw_byte_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [jbps_pkg::ByteW-1:0]       out_byte_o,
  output logic                             last_o
);

  logic [jbps_pkg::PendW-1:0] pend_q, pend_d;
  logic [jbps_pkg::CntW-1:0]  cnt_q, cnt_d;
  logic [jbps_pkg::AccW-1:0]  acc_q, acc_d;
  logic [jbps_pkg::TotW-1:0]  tot_q, tot_d;
  logic                       raw_q, raw_d;
  logic                       out_valid_q, out_valid_d;
  logic [jbps_pkg::ByteW-1:0] out_byte_q, out_byte_d;
  logic                       last_q, last_d;

  logic [jbps_pkg::LenW-1:0]  len_sat;
  logic [16:0]                code_mask;
  logic [jbps_pkg::CodeW-1:0] code_m;
  logic [jbps_pkg::AccW-1:0]  acc_app;
  logic [jbps_pkg::TotW-1:0]  tot_app;
  logic [7:0]                 pend_mask;
  logic [3:0]                 pad;
  logic [15:0]                al_w;
  logic [jbps_pkg::TotW-1:0]  sh;
  logic [jbps_pkg::AccW-1:0]  cur_w;
  logic [jbps_pkg::ByteW-1:0] cur_byte;
  logic                       byte_ff;

  // Append: saturate the length, drop code bits above it.
  always_comb begin
    len_sat   = (code_length_i > 5'd16) ? 5'd16 : code_length_i;
    code_mask = (17'd1 << len_sat) - 17'd1;
    code_m    = code_value_i & code_mask[15:0];
    acc_app   = ({16'd0, pend_q} << len_sat) | {7'd0, code_m};
    tot_app   = {2'd0, cnt_q} + len_sat;
    pend_mask = (8'd1 << tot_app[2:0]) - 8'd1;
    pad       = 4'd8 - {1'b0, cnt_q};
    al_w      = ({9'd0, pend_q} << pad) | ((16'd1 << pad) - 16'd1);
  end

  always_comb begin
    acc_d  = acc_q;
    tot_d  = tot_q;
    raw_d  = raw_q;
    pend_d = pend_q;
    cnt_d  = cnt_q;
    if (cmd_i.load) begin
      raw_d = 1'b0;
      unique case (command_i)
        jbps_pkg::CmdAppend: begin
          acc_d  = acc_app;
          tot_d  = tot_app;
          pend_d = acc_app[6:0] & pend_mask[6:0];
          cnt_d  = tot_app[2:0];
        end
        jbps_pkg::CmdAlign: begin
          acc_d  = {15'd0, al_w[7:0]};
          tot_d  = (cnt_q != 3'd0) ? 5'd8 : 5'd0;
          pend_d = '0;
          cnt_d  = '0;
        end
        jbps_pkg::CmdRaw: begin
          acc_d = {15'd0, raw_byte_i};
          tot_d = 5'd8;
          raw_d = 1'b1;
        end
        default: begin
          tot_d = 5'd0;
        end
      endcase
    end else if (cmd_i.emit_byte) begin
      tot_d = tot_q - 5'd8;
    end
  end

  // Byte at the top of the valid window.
  always_comb begin
    sh       = tot_q - 5'd8;
    cur_w    = acc_q >> sh;
    cur_byte = cur_w[7:0];
    byte_ff  = (cur_byte == jbps_pkg::ByteFf) && !raw_q;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    last_d      = last_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.emit_byte) begin
      out_valid_d = 1'b1;
      out_byte_d  = cur_byte;
      last_d      = (tot_q < 5'd16) && !byte_ff;
    end else if (cmd_i.emit_stuff) begin
      out_valid_d = 1'b1;
      out_byte_d  = jbps_pkg::ByteStuff;
      last_d      = (tot_q < 5'd8);
    end
  end

  always_comb begin
    sts_o.ld_emits   = (command_i == jbps_pkg::CmdRaw) ||
                       ((command_i == jbps_pkg::CmdAppend) && (tot_app >= 5'd8)) ||
                       ((command_i == jbps_pkg::CmdAlign) && (cnt_q != 3'd0));
    sts_o.more       = (tot_q >= 5'd8);
    sts_o.final_byte = (tot_q < 5'd16);
    sts_o.byte_ff    = byte_ff;
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= '0;
      cnt_q       <= '0;
      tot_q       <= '0;
      raw_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q      <= pend_d;
      cnt_q       <= cnt_d;
      tot_q       <= tot_d;
      raw_q       <= raw_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q      <= acc_d;
    out_byte_q <= out_byte_d;
    last_q     <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign last_o      = last_q;

  // A stuffed zero only ever follows a 0xFF byte.
  a_stuff_after_ff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_stuff |-> (out_byte_q == jbps_pkg::ByteFf) && !last_q)
    else $error("stuffed zero without preceding 0xFF");

  // Never overwrite a beat still waiting at the output.
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit_byte || cmd_i.emit_stuff) |-> (!out_valid_q || out_ready_i))
    else $error("output beat overwritten");

endmodule

// ----- sv/jbps_ctrl.sv -----
`timescale 1ns / 1ps

module jbps_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  jbps_pkg::sts_t sts_i,
  output jbps_pkg::cmd_t cmd_o
);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StEmit  = 2'd1;
  localparam logic [1:0] StStuff = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (sts_i.ld_emits) begin
            state_d = StEmit;
          end
        end
      end
      StEmit: begin
        if (sts_i.out_free) begin
          cmd_o.emit_byte = 1'b1;
          if (sts_i.byte_ff) begin
            state_d = StStuff;
          end else if (sts_i.final_byte) begin
            state_d = StIdle;
          end
        end
      end
      StStuff: begin
        if (sts_i.out_free) begin
          cmd_o.emit_stuff = 1'b1;
          state_d = sts_i.more ? StEmit : StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Emit state is entered only with a whole byte pending.
  a_emit_has_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StEmit) |-> sts_i.more)
    else $error("emit state without a complete byte");

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load, cmd_o.emit_byte, cmd_o.emit_stuff}))
    else $error("conflicting datapath commands");

endmodule

// ----- sv/jpeg_bit_packer_stuffing_core.sv -----
`timescale 1ns / 1ps

// JPEG entropy bit writer with 0xFF byte stuffing. Each input beat carries a
// command: append (code_value_i, low code_length_i bits, MSB first, length
// saturated at 16), align (pad pending bits with ones to a byte and empty the
// store) or raw (raw_byte_i emitted unstuffed, pending bits kept). Completed
// bytes leave one per output beat; a 0xFF from append or align is followed by
// a 0x00 beat, and last_o marks the final beat caused by an input. An input
// beat is loaded on the controller's load command, and each output beat it
// causes then passes through the single output register, issued only while
// that register is free; an item yields at most four output beats. The next
// input beat is accepted once the controller has sent the previous item's
// last byte into the output register, even while that byte still waits to
// be taken.
module jpeg_bit_packer_stuffing_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [jbps_pkg::CmdW-1:0]   command_i,
  input  logic [jbps_pkg::CodeW-1:0]  code_value_i,
  input  logic [jbps_pkg::LenW-1:0]   code_length_i,
  input  logic [jbps_pkg::ByteW-1:0]  raw_byte_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [jbps_pkg::ByteW-1:0]  out_byte_o,
  output logic                        last_o
);

  // Command and status between sequencer and datapath.
  jbps_pkg::cmd_t cmd;
  jbps_pkg::sts_t sts;

  jbps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  jbps_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .command_i     (command_i),
    .code_value_i  (code_value_i),
    .code_length_i (code_length_i),
    .raw_byte_i    (raw_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_o    (out_byte_o),
    .last_o        (last_o)
  );

endmodule
